>>> rtl/csvrs_pkg.sv
package csvrs_pkg;

  localparam int LINE_COUNT_BITS = 16;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS   = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 16;

  localparam logic [7:0] BYTE_LF = 8'd10;
  localparam logic [7:0] BYTE_CR = 8'd13;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_DISCARD = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OPEN_QUOTE = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_DELIMITER       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_QUOTE_BYTE      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COMMENT_BYTE    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COMMENT_ENABLE  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_QUOTED_NEWLINES = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SKIP_BLANK      = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_LINE        = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DROP_LEFTOVER   = 3'd7;

  typedef enum logic [6:0] {
    ST_NEW        = 7'b0000001,
    ST_FIELD      = 7'b0000010,
    ST_QUOTED     = 7'b0000100,
    ST_QQ         = 7'b0001000,
    ST_CR         = 7'b0010000,
    ST_COMMENT    = 7'b0100000,
    ST_COMMENT_CR = 7'b1000000
  } parse_state_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] error_code;
    logic       last;
  } out_item_t;

endpackage

>>> rtl/csv_record_splitter.sv
// channel | ports                         | payload
// in      | in_valid, in_ready, in_data   | in_item_t: operation, in_byte
// out     | out_valid, out_ready, out_data| out_item_t: kind, out_byte, error_code, last
// cfg     | cfg_valid, cfg_ready          | cfg_index, cfg_data (always ready)
//
// one input beat per ready cycle: the parser state updates in the accept cycle and its
// zero to two results go into a four-entry result queue that drives out_data
// in_ready is high while the queue has room for two results, so an item with two
// results (lone cr followed by a byte, or a discard and an error) briefly outpaces
// the single output beat per cycle and out_ready stalls back up through the queue
// synchronous active-low reset returns to line start, clears the sticky error,
// empties the queue and loads the register defaults
module csv_record_splitter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  csvrs_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output csvrs_pkg::out_item_t               out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [csvrs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [csvrs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import csvrs_pkg::*;

  localparam logic [LINE_COUNT_BITS-1:0] CNT_MAX = {LINE_COUNT_BITS{1'b1}};

  // configuration registers
  logic [7:0]  delimiter_r, quote_byte_r, comment_byte_r;
  logic        comment_enable_r, quoted_newlines_r, skip_blank_r, drop_leftover_r;
  logic [15:0] max_line_r;

  // parser state
  parse_state_t                state_r, state_nxt;
  logic [LINE_COUNT_BITS-1:0]  line_count_r, line_count_nxt;
  logic                        line_started_r, line_started_nxt;
  logic                        payload_seen_r, payload_seen_nxt;
  logic                        error_stuck_r, error_stuck_nxt;

  // result queue
  out_item_t                   fifo_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0]    wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_BITS-1:0]    fifo_cnt_r;

  out_item_t                   res_w [2];
  logic [1:0]                  nres_w;
  logic                        go_w;
  logic [7:0]                  b_w;
  logic                        in_acc, out_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (fifo_cnt_r <= FIFO_CNT_BITS'(2));
  assign out_valid = (fifo_cnt_r != '0);
  assign out_data  = fifo_r[rd_ptr_r];
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign b_w       = in_data.in_byte;

  function automatic out_item_t mk_res(logic [1:0] kind, logic [7:0] b, logic [1:0] code);
    out_item_t r;
    r.kind       = kind;
    r.out_byte   = b;
    r.error_code = code;
    r.last       = 1'b0;
    return r;
  endfunction

  always_comb begin
    state_nxt        = state_r;
    line_count_nxt   = line_count_r;
    line_started_nxt = line_started_r;
    payload_seen_nxt = payload_seen_r;
    error_stuck_nxt  = error_stuck_r;
    res_w[0]         = mk_res(KIND_PAYLOAD, 8'd0, ERR_NONE);
    res_w[1]         = mk_res(KIND_PAYLOAD, 8'd0, ERR_NONE);
    nres_w           = 2'd0;
    go_w             = 1'b1;

    if (in_acc && !error_stuck_r) begin
      if (in_data.operation) begin
        // end of input
        if (line_started_nxt && state_nxt != ST_COMMENT && state_nxt != ST_COMMENT_CR) begin
          if (drop_leftover_r) begin
            if (payload_seen_nxt) begin
              res_w[nres_w[0]] = mk_res(KIND_DISCARD, 8'd0, ERR_NONE);
              nres_w = nres_w + 2'd1;
            end
          end else if (state_nxt == ST_QUOTED) begin
            if (payload_seen_nxt) begin
              res_w[nres_w[0]] = mk_res(KIND_DISCARD, 8'd0, ERR_NONE);
              nres_w = nres_w + 2'd1;
            end
            res_w[nres_w[0]] = mk_res(KIND_ERROR, 8'd0, ERR_OPEN_QUOTE);
            nres_w = nres_w + 2'd1;
            error_stuck_nxt = 1'b1;
          end else if (payload_seen_nxt || !skip_blank_r) begin
            res_w[nres_w[0]] = mk_res(KIND_END, 8'd0, ERR_NONE);
            nres_w = nres_w + 2'd1;
          end
        end
        state_nxt        = ST_NEW;
        line_count_nxt   = '0;
        line_started_nxt = 1'b0;
        payload_seen_nxt = 1'b0;
      end else begin
        if (state_r == ST_CR || state_r == ST_COMMENT_CR) begin
          if (b_w == BYTE_LF) begin
            go_w = 1'b0;
            if (state_r == ST_CR) begin
              // lf of cr lf counts toward the line length
              if (line_count_nxt != CNT_MAX) line_count_nxt = line_count_nxt + 1'b1;
              if (max_line_r != '0 && 32'(line_count_nxt) >= 32'(max_line_r)) begin
                if (payload_seen_nxt) begin
                  res_w[nres_w[0]] = mk_res(KIND_DISCARD, 8'd0, ERR_NONE);
                  nres_w = nres_w + 2'd1;
                end
                res_w[nres_w[0]] = mk_res(KIND_ERROR, 8'd0, ERR_TOO_LONG);
                nres_w = nres_w + 2'd1;
                error_stuck_nxt = 1'b1;
              end else if (payload_seen_nxt || !skip_blank_r) begin
                res_w[nres_w[0]] = mk_res(KIND_END, 8'd0, ERR_NONE);
                nres_w = nres_w + 2'd1;
              end
            end
          end else if (state_r == ST_CR && (payload_seen_nxt || !skip_blank_r)) begin
            // lone cr ends the record, this byte starts the next line
            res_w[nres_w[0]] = mk_res(KIND_END, 8'd0, ERR_NONE);
            nres_w = nres_w + 2'd1;
          end
          state_nxt        = ST_NEW;
          line_count_nxt   = '0;
          line_started_nxt = 1'b0;
          payload_seen_nxt = 1'b0;
        end else if (state_r == ST_COMMENT) begin
          go_w = 1'b0;
          if (b_w == BYTE_LF) begin
            state_nxt        = ST_NEW;
            line_count_nxt   = '0;
            line_started_nxt = 1'b0;
            payload_seen_nxt = 1'b0;
          end else if (b_w == BYTE_CR) begin
            state_nxt = ST_COMMENT_CR;
          end
        end

        if (go_w && !line_started_nxt) begin
          line_started_nxt = 1'b1;
          if (comment_enable_r && b_w == comment_byte_r) begin
            state_nxt = ST_COMMENT;
            go_w      = 1'b0;
          end
        end

        if (go_w) begin
          if (line_count_nxt != CNT_MAX) line_count_nxt = line_count_nxt + 1'b1;
          if (max_line_r != '0 && 32'(line_count_nxt) >= 32'(max_line_r)) begin
            if (payload_seen_nxt) begin
              res_w[nres_w[0]] = mk_res(KIND_DISCARD, 8'd0, ERR_NONE);
              nres_w = nres_w + 2'd1;
            end
            res_w[nres_w[0]] = mk_res(KIND_ERROR, 8'd0, ERR_TOO_LONG);
            nres_w = nres_w + 2'd1;
            error_stuck_nxt  = 1'b1;
            state_nxt        = ST_NEW;
            line_count_nxt   = '0;
            line_started_nxt = 1'b0;
            payload_seen_nxt = 1'b0;
          end else begin
            case (state_nxt)
              ST_FIELD: begin
                if (b_w == delimiter_r) begin
                  res_w[nres_w[0]] = mk_res(KIND_PAYLOAD, b_w, ERR_NONE);
                  nres_w = nres_w + 2'd1;
                  payload_seen_nxt = 1'b1;
                  state_nxt = ST_NEW;
                end else if (b_w == BYTE_LF) begin
                  if (payload_seen_nxt || !skip_blank_r) begin
                    res_w[nres_w[0]] = mk_res(KIND_END, 8'd0, ERR_NONE);
                    nres_w = nres_w + 2'd1;
                  end
                  state_nxt        = ST_NEW;
                  line_count_nxt   = '0;
                  line_started_nxt = 1'b0;
                  payload_seen_nxt = 1'b0;
                end else if (b_w == BYTE_CR) begin
                  state_nxt = ST_CR;
                end else begin
                  res_w[nres_w[0]] = mk_res(KIND_PAYLOAD, b_w, ERR_NONE);
                  nres_w = nres_w + 2'd1;
                  payload_seen_nxt = 1'b1;
                  state_nxt = ST_FIELD;
                end
              end
              ST_QUOTED: begin
                res_w[nres_w[0]] = mk_res(KIND_PAYLOAD, b_w, ERR_NONE);
                nres_w = nres_w + 2'd1;
                payload_seen_nxt = 1'b1;
                state_nxt = (b_w == quote_byte_r) ? ST_QQ : ST_QUOTED;
              end
              ST_QQ: begin
                if (b_w == delimiter_r) begin
                  res_w[nres_w[0]] = mk_res(KIND_PAYLOAD, b_w, ERR_NONE);
                  nres_w = nres_w + 2'd1;
                  payload_seen_nxt = 1'b1;
                  state_nxt = ST_NEW;
                end else if (b_w == quote_byte_r) begin
                  // doubled quote, still inside the quoted field
                  res_w[nres_w[0]] = mk_res(KIND_PAYLOAD, b_w, ERR_NONE);
                  nres_w = nres_w + 2'd1;
                  payload_seen_nxt = 1'b1;
                  state_nxt = ST_QUOTED;
                end else if (b_w == BYTE_LF) begin
                  if (payload_seen_nxt || !skip_blank_r) begin
                    res_w[nres_w[0]] = mk_res(KIND_END, 8'd0, ERR_NONE);
                    nres_w = nres_w + 2'd1;
                  end
                  state_nxt        = ST_NEW;
                  line_count_nxt   = '0;
                  line_started_nxt = 1'b0;
                  payload_seen_nxt = 1'b0;
                end else if (b_w == BYTE_CR) begin
                  state_nxt = ST_CR;
                end else begin
                  res_w[nres_w[0]] = mk_res(KIND_PAYLOAD, b_w, ERR_NONE);
                  nres_w = nres_w + 2'd1;
                  payload_seen_nxt = 1'b1;
                  state_nxt = ST_FIELD;
                end
              end
              default: begin
                if (b_w == delimiter_r) begin
                  res_w[nres_w[0]] = mk_res(KIND_PAYLOAD, b_w, ERR_NONE);
                  nres_w = nres_w + 2'd1;
                  payload_seen_nxt = 1'b1;
                  state_nxt = ST_NEW;
                end else if (quoted_newlines_r && b_w == quote_byte_r) begin
                  res_w[nres_w[0]] = mk_res(KIND_PAYLOAD, b_w, ERR_NONE);
                  nres_w = nres_w + 2'd1;
                  payload_seen_nxt = 1'b1;
                  state_nxt = ST_QUOTED;
                end else if (b_w == BYTE_LF) begin
                  if (payload_seen_nxt || !skip_blank_r) begin
                    res_w[nres_w[0]] = mk_res(KIND_END, 8'd0, ERR_NONE);
                    nres_w = nres_w + 2'd1;
                  end
                  state_nxt        = ST_NEW;
                  line_count_nxt   = '0;
                  line_started_nxt = 1'b0;
                  payload_seen_nxt = 1'b0;
                end else if (b_w == BYTE_CR) begin
                  state_nxt = ST_CR;
                end else begin
                  res_w[nres_w[0]] = mk_res(KIND_PAYLOAD, b_w, ERR_NONE);
                  nres_w = nres_w + 2'd1;
                  payload_seen_nxt = 1'b1;
                  state_nxt = ST_FIELD;
                end
              end
            endcase
          end
        end
      end
    end

    if (nres_w == 2'd2) begin
      res_w[1].last = 1'b1;
    end else if (nres_w == 2'd1) begin
      res_w[0].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_r       <= 8'd44;
      quote_byte_r      <= 8'd34;
      comment_byte_r    <= 8'd35;
      comment_enable_r  <= 1'b0;
      quoted_newlines_r <= 1'b1;
      skip_blank_r      <= 1'b0;
      max_line_r        <= 16'd0;
      drop_leftover_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DELIMITER:       delimiter_r       <= cfg_data[7:0];
        CFG_QUOTE_BYTE:      quote_byte_r      <= cfg_data[7:0];
        CFG_COMMENT_BYTE:    comment_byte_r    <= cfg_data[7:0];
        CFG_COMMENT_ENABLE:  comment_enable_r  <= cfg_data[0];
        CFG_QUOTED_NEWLINES: quoted_newlines_r <= cfg_data[0];
        CFG_SKIP_BLANK:      skip_blank_r      <= cfg_data[0];
        CFG_MAX_LINE:        max_line_r        <= cfg_data[15:0];
        CFG_DROP_LEFTOVER:   drop_leftover_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_NEW;
      line_count_r   <= '0;
      line_started_r <= 1'b0;
      payload_seen_r <= 1'b0;
      error_stuck_r  <= 1'b0;
      wr_ptr_r       <= '0;
      rd_ptr_r       <= '0;
      fifo_cnt_r     <= '0;
    end else begin
      state_r        <= state_nxt;
      line_count_r   <= line_count_nxt;
      line_started_r <= line_started_nxt;
      payload_seen_r <= payload_seen_nxt;
      error_stuck_r  <= error_stuck_nxt;
      wr_ptr_r       <= wr_ptr_r + FIFO_PTR_BITS'(nres_w);
      if (out_acc) rd_ptr_r <= rd_ptr_r + 1'b1;
      fifo_cnt_r     <= fifo_cnt_r + FIFO_CNT_BITS'(nres_w) - FIFO_CNT_BITS'(out_acc);
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (nres_w != 2'd0) fifo_r[wr_ptr_r] <= res_w[0];
    if (nres_w == 2'd2) fifo_r[wr_ptr_r + 1'b1] <= res_w[1];
  end

`ifndef SYNTH
  a_stuck_holds: assert property (@(posedge clk) disable iff (!rst_n)
    error_stuck_r |=> error_stuck_r)
    else $error("sticky error cleared without reset");

  a_no_results_when_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    error_stuck_r |-> nres_w == 2'd0)
    else $error("result produced while error is stuck");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (nres_w != 2'd0) |=> out_valid)
    else $error("pushed result not presented");

  a_code_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind != KIND_ERROR) |-> out_data.error_code == ERR_NONE)
    else $error("error code on a non-error result");
`endif

endmodule
